[sv/rpfd_pkg.sv]
// ----------------------------------------------------------------------------
// rpfd_pkg
// Types and fixed timing constants for the remote-control pulse frame decoder.
// ----------------------------------------------------------------------------
package rpfd_pkg;

    localparam int DUR_W       = 17;
    localparam int FRAME_BYTES = 7;
    localparam logic [2:0] LAST_BYTE = 3'(FRAME_BYTES - 1);

    // Result status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_FRAME    = 2'd1;
    localparam logic [1:0] STATUS_TIMING   = 2'd2;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

    // Nominal pulse lengths in microseconds, matched within +/-10%
    localparam int TOL_NUM = 10;
    localparam int TOL_DEN = 100;
    localparam int T_WAKE  = 12400;
    localparam int T_GAP   = 80600;
    localparam int T_HSYNC = 2560;
    localparam int T_SSYNC = 4800;

    localparam logic [DUR_W-1:0] WAKE_LO  = DUR_W'(T_WAKE - T_WAKE * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] WAKE_HI  = DUR_W'(T_WAKE + T_WAKE * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] GAP_LO   = DUR_W'(T_GAP - T_GAP * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] GAP_HI   = DUR_W'(T_GAP + T_GAP * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] HSYNC_LO = DUR_W'(T_HSYNC - T_HSYNC * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] HSYNC_HI = DUR_W'(T_HSYNC + T_HSYNC * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] SSYNC_LO = DUR_W'(T_SSYNC - T_SSYNC * TOL_NUM / TOL_DEN);
    localparam logic [DUR_W-1:0] SSYNC_HI = DUR_W'(T_SSYNC + T_SSYNC * TOL_NUM / TOL_DEN);

    localparam logic [DUR_W-1:0] SYNC_END_MIN = DUR_W'(660);
    localparam logic [DUR_W-1:0] SYNC_END_CUT = DUR_W'(800);
    localparam logic [DUR_W-1:0] RESIDUE_MIN  = DUR_W'(400);
    localparam logic [DUR_W-1:0] BIT_MAX      = DUR_W'(2000);
    localparam logic [DUR_W-1:0] HALF_MAX     = DUR_W'(1100);

    localparam logic [3:0] HSYNC_START = 4'd10;
    localparam logic [3:0] HSYNC_DONE  = 4'd14;

    typedef struct packed {
        logic [1:0]       channel;
        logic             level;
        logic [DUR_W-1:0] duration_us;
    } pulse_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  frame_key;
        logic [3:0]  command;
        logic [15:0] rolling_code;
        logic [23:0] remote_address;
    } frame_t;

    typedef struct packed {
        logic start;
        logic pre_step;
        logic bit_step;
        logic rd_step;
        logic chk_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic pre_go;
        logic bit_done;
        logic frame_end;
        logic rd_last;
    } dp_sts_t;

endpackage

[sv/rpfd_datapath.sv]
// ----------------------------------------------------------------------------
// rpfd_datapath
// Per-channel preamble and bit state, frame byte memory, frame decode and
// result register.
// ----------------------------------------------------------------------------
module rpfd_datapath #(
    parameter int CHANNELS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rpfd_pkg::pulse_t  pulse,
    input  rpfd_pkg::dp_cmd_t cmd,
    output rpfd_pkg::dp_sts_t sts,
    output rpfd_pkg::frame_t  frame
);
    import rpfd_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * FRAME_BYTES;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [1:0] PRE_WAKE  = 2'd1;
    localparam logic [1:0] PRE_GAP   = 2'd2;
    localparam logic [1:0] SOFT_IDLE = 2'd0;
    localparam logic [1:0] SOFT_SEEN = 2'd1;
    localparam logic [1:0] SOFT_DONE = 2'd2;

    localparam logic [2:0] BYTE_KEY   = 3'd0;
    localparam logic [2:0] BYTE_CMD   = 3'd1;
    localparam logic [2:0] BYTE_CODEH = 3'd2;
    localparam logic [2:0] BYTE_CODEL = 3'd3;
    localparam logic [2:0] BYTE_ADDR0 = 3'd4;
    localparam logic [2:0] BYTE_ADDR1 = 3'd5;
    localparam logic [2:0] BYTE_ADDR2 = 3'd6;

    // Per-channel state
    logic       synced_reg    [CHANNELS];
    logic [1:0] pre_stage_reg [CHANNELS];
    logic [3:0] sync_cnt_reg  [CHANNELS];
    logic [1:0] soft_reg      [CHANNELS];
    logic       half_reg      [CHANNELS];
    logic [7:0] shift_reg     [CHANNELS];
    logic [2:0] cd_reg        [CHANNELS];
    logic [2:0] idx_reg       [CHANNELS];

    logic [7:0] frame_mem [MEM_DEPTH];

    // Current transaction
    logic [1:0]       ch_reg;
    logic             lvl_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [DUR_W-1:0] dur_next;

    logic [CH_W-1:0] ch_idx;
    logic            ch_ok;
    logic [AW-1:0]   base_addr;

    logic       cur_synced;
    logic [1:0] cur_stage;
    logic [3:0] cur_cnt;
    logic [1:0] cur_soft;
    logic       cur_half;
    logic [7:0] cur_shift;
    logic [2:0] cur_cd;
    logic [2:0] cur_idx;

    logic       synced_next;
    logic [1:0] stage_next;
    logic [3:0] cnt_next;
    logic [1:0] soft_next;
    logic       half_next;
    logic [7:0] shift_next;
    logic [2:0] cd_next;
    logic [2:0] idx_next;

    logic       state_we;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic       rd_en;
    logic       timing_err;
    logic       pre_go;
    logic       bit_done;
    logic       frame_end;

    // Decode
    logic [2:0] rd_cnt_reg;
    logic [7:0] rd_data_reg;
    logic [7:0] prev_reg;
    logic [3:0] sum_reg;
    logic [3:0] chk_reg;
    logic [2:0] dec_idx;
    logic [7:0] plain;
    logic [7:0] sum_term;

    frame_t res_reg;
    frame_t out_reg;

    assign ch_idx    = CH_W'(ch_reg);
    assign ch_ok     = int'(ch_reg) < CHANNELS;
    assign base_addr = AW'(ch_idx) * AW'(FRAME_BYTES);

    assign cur_synced = synced_reg[ch_idx];
    assign cur_stage  = pre_stage_reg[ch_idx];
    assign cur_cnt    = sync_cnt_reg[ch_idx];
    assign cur_soft   = soft_reg[ch_idx];
    assign cur_half   = half_reg[ch_idx];
    assign cur_shift  = shift_reg[ch_idx];
    assign cur_cd     = cd_reg[ch_idx];
    assign cur_idx    = idx_reg[ch_idx];

    always_comb
    begin
        synced_next = cur_synced;
        stage_next  = cur_stage;
        cnt_next    = cur_cnt;
        soft_next   = cur_soft;
        half_next   = cur_half;
        shift_next  = cur_shift;
        cd_next     = cur_cd;
        idx_next    = cur_idx;
        dur_next    = dur_reg;
        pre_go      = 1'b0;
        bit_done    = 1'b0;
        frame_end   = 1'b0;
        timing_err  = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = cur_shift | {7'b0, lvl_reg};

        if (cmd.pre_step && ch_ok)
        begin
            if (cur_synced)
            begin
                pre_go = 1'b1;
            end
            else if (lvl_reg && dur_reg > WAKE_LO && dur_reg < WAKE_HI)
            begin
                stage_next = PRE_WAKE;
            end
            else if (!lvl_reg && cur_stage == PRE_WAKE && dur_reg > GAP_LO && dur_reg < GAP_HI)
            begin
                stage_next = PRE_GAP;
                cnt_next   = HSYNC_START;
            end
            else if (cur_stage == PRE_GAP && cur_cnt != HSYNC_DONE &&
                     dur_reg > HSYNC_LO && dur_reg < HSYNC_HI)
            begin
                cnt_next = cur_cnt + 4'd1;
            end
            else if (cur_cnt == HSYNC_DONE && cur_soft == SOFT_IDLE &&
                     dur_reg > SSYNC_LO && dur_reg < SSYNC_HI)
            begin
                soft_next = SOFT_SEEN;
            end
            else if (cur_soft == SOFT_SEEN && dur_reg >= SYNC_END_MIN)
            begin
                // sync end: whatever is left past the cut is already data
                dur_next    = (dur_reg >= SYNC_END_CUT) ? dur_reg - SYNC_END_CUT : '0;
                soft_next   = SOFT_DONE;
                synced_next = 1'b1;
                pre_go      = dur_next >= RESIDUE_MIN;
            end
            else
            begin
                cnt_next  = 4'd0;
                soft_next = SOFT_IDLE;
            end
        end

        if (cmd.bit_step)
        begin
            if (dur_reg == '0)
            begin
                bit_done = 1'b1;
            end
            else if (cur_idx != LAST_BYTE && dur_reg > BIT_MAX)
            begin
                timing_err  = 1'b1;
                bit_done    = 1'b1;
                synced_next = 1'b0;
                idx_next    = 3'd0;
                half_next   = 1'b0;
                shift_next  = 8'd0;
                cd_next     = 3'd7;
            end
            else
            begin
                dur_next = (dur_reg > HALF_MAX) ? (dur_reg >> 1) : '0;
                bit_done = dur_next == '0;
                if (!cur_half)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    // second half of a bit: its level is the bit value
                    half_next = 1'b0;
                    if (cur_cd != 3'd0)
                    begin
                        shift_next = cur_shift | (8'(lvl_reg) << cur_cd);
                        cd_next    = cur_cd - 3'd1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        shift_next = 8'd0;
                        cd_next    = 3'd7;
                        if (cur_idx == LAST_BYTE)
                        begin
                            frame_end   = 1'b1;
                            bit_done    = 1'b1;
                            synced_next = 1'b0;
                            idx_next    = 3'd0;
                        end
                        else
                        begin
                            idx_next = cur_idx + 3'd1;
                        end
                    end
                end
            end
        end
    end

    assign state_we = (cmd.pre_step && ch_ok) || cmd.bit_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                synced_reg[c]    <= 1'b0;
                pre_stage_reg[c] <= 2'd0;
                sync_cnt_reg[c]  <= 4'd0;
                soft_reg[c]      <= SOFT_IDLE;
                half_reg[c]      <= 1'b0;
                shift_reg[c]     <= 8'd0;
                cd_reg[c]        <= 3'd7;
                idx_reg[c]       <= 3'd0;
            end
            rd_cnt_reg <= 3'd0;
        end
        else
        begin
            if (state_we)
            begin
                synced_reg[ch_idx]    <= synced_next;
                pre_stage_reg[ch_idx] <= stage_next;
                sync_cnt_reg[ch_idx]  <= cnt_next;
                soft_reg[ch_idx]      <= soft_next;
                half_reg[ch_idx]      <= half_next;
                shift_reg[ch_idx]     <= shift_next;
                cd_reg[ch_idx]        <= cd_next;
                idx_reg[ch_idx]       <= idx_next;
            end
            if (cmd.start)
            begin
                rd_cnt_reg <= 3'd0;
            end
            else if (cmd.rd_step)
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
        end
    end

    // Frame byte memory: one write port, one registered read port
    assign rd_en = cmd.rd_step && rd_cnt_reg != 3'(FRAME_BYTES);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[base_addr + AW'(cur_idx)] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[base_addr + AW'(rd_cnt_reg)];
        end
    end

    // Read data lags the count by one; undo the XOR chaining byte by byte
    assign dec_idx  = rd_cnt_reg - 3'd1;
    assign plain    = (dec_idx == BYTE_KEY) ? rd_data_reg : (rd_data_reg ^ prev_reg);
    assign sum_term = (dec_idx == BYTE_CMD) ? {plain[7:4], 4'h0} : plain;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ch_reg  <= pulse.channel;
            lvl_reg <= pulse.level;
            dur_reg <= pulse.duration_us;
            res_reg <= '0;
            sum_reg <= 4'h0;
        end
        else
        begin
            dur_reg <= dur_next;
            if (cmd.bit_step && timing_err)
            begin
                res_reg.frame_status <= STATUS_TIMING;
            end
            if (cmd.rd_step && rd_cnt_reg != 3'd0)
            begin
                prev_reg <= rd_data_reg;
                sum_reg  <= sum_reg ^ sum_term[7:4] ^ sum_term[3:0];
                case (dec_idx)
                    BYTE_KEY:   res_reg.frame_key <= plain;
                    BYTE_CMD:
                    begin
                        res_reg.command <= plain[7:4];
                        chk_reg         <= plain[3:0];
                    end
                    BYTE_CODEH: res_reg.rolling_code[15:8]   <= plain;
                    BYTE_CODEL: res_reg.rolling_code[7:0]    <= plain;
                    BYTE_ADDR0: res_reg.remote_address[7:0]  <= plain;
                    BYTE_ADDR1: res_reg.remote_address[15:8] <= plain;
                    BYTE_ADDR2: res_reg.remote_address[23:16] <= plain;
                    default:    ;
                endcase
            end
            if (cmd.chk_step)
            begin
                res_reg.frame_status <= (sum_reg == chk_reg) ? STATUS_FRAME : STATUS_CHECKSUM;
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign sts.pre_go    = pre_go;
    assign sts.bit_done  = bit_done;
    assign sts.frame_end = frame_end;
    assign sts.rd_last   = rd_cnt_reg == 3'(FRAME_BYTES);
    assign frame         = out_reg;

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bit_step && frame_end) |=> (!cur_synced && cur_idx == 3'd0))
        else $error("frame end did not release the channel");

    a_timing_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bit_step && timing_err) |=> (res_reg.frame_status == STATUS_TIMING && !cur_synced))
        else $error("timing error not reflected in status or sync");

    a_empty_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (res_reg.frame_status == STATUS_NONE ||
                          res_reg.frame_status == STATUS_TIMING))
        |=> (frame.frame_key == 8'd0 && frame.command == 4'd0 &&
             frame.rolling_code == 16'd0 && frame.remote_address == 24'd0))
        else $error("non-frame result carries frame fields");

endmodule

[sv/rpfd_ctrl.sv]
// ----------------------------------------------------------------------------
// rpfd_ctrl
// Sequencer: accepts a pulse, steps preamble and half-bit work, runs the frame
// read-back and hands the result to the output register.
// ----------------------------------------------------------------------------
module rpfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pulse_valid,
    output logic              pulse_stall,
    output logic              frame_valid,
    input  logic              frame_stall,
    input  rpfd_pkg::dp_sts_t sts,
    output rpfd_pkg::dp_cmd_t cmd
);
    import rpfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_BIT,
        S_RD,
        S_CHK,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   frame_valid_reg;
    logic   frame_valid_next;
    logic   pulse_stall_reg;
    logic   pulse_stall_next;
    logic   out_free;

    assign out_free = !frame_valid_reg || !frame_stall;

    always_comb
    begin
        state_next       = state_reg;
        frame_valid_next = frame_valid_reg && frame_stall;
        cmd              = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (pulse_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.pre_step = 1'b1;
                state_next   = sts.pre_go ? S_BIT : S_OUT;
            end
            S_BIT:
            begin
                cmd.bit_step = 1'b1;
                if (sts.frame_end)
                begin
                    state_next = S_RD;
                end
                else if (sts.bit_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_RD:
            begin
                cmd.rd_step = 1'b1;
                if (sts.rd_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd.chk_step = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out     = 1'b1;
                    frame_valid_next = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pulse_stall_next = state_next != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            frame_valid_reg <= 1'b0;
            pulse_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_valid_reg <= frame_valid_next;
            pulse_stall_reg <= pulse_stall_next;
        end
    end

    assign pulse_stall = pulse_stall_reg;
    assign frame_valid = frame_valid_reg;

    a_stall_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_stall_reg == (state_reg != S_IDLE))
        else $error("input stall out of step with sequencer");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && frame_valid_reg && frame_stall) |=> state_reg == S_OUT)
        else $error("result left before output register was free");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (frame_valid_reg && state_reg == S_IDLE))
        else $error("loaded result not presented");

endmodule

[sv/rts_pulse_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rts_pulse_frame_decoder
// Manchester remote-control frame receiver working on timed line pulses.
// ----------------------------------------------------------------------------
// Input channel pulse / pulse_valid / pulse_stall: one transaction per pulse,
// giving the receiver line, its level and its length in microseconds.
// Output channel frame / frame_valid / frame_stall: exactly one transaction
// per pulse, with a status (none, frame, timing error, checksum error) and the
// decoded key, command, rolling code and address.
// A pulse is taken, passes the preamble step and then its half-bit steps; a long
// pulse in the last byte needs more steps, because the halving unit cuts one
// half-bit per cycle. A pulse that completes a frame then reads back the seven
// stored bytes, one per cycle from the single-read-port frame memory, followed
// by the checksum compare.
// One pulse is in work at a time; pulse_stall is high from acceptance until
// its result sits in the output register. That register frees the work side,
// so a new pulse is taken while frame_valid is stalled, and its result waits
// until the previous one is taken.
// Reset clears all channels to the unsynced preamble state and drops any
// pending result. Frame memory needs no clearing.
// ----------------------------------------------------------------------------
module rts_pulse_frame_decoder #(
    parameter int CHANNELS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pulse_valid,
    output logic             pulse_stall,
    input  rpfd_pkg::pulse_t pulse,
    output logic             frame_valid,
    input  logic             frame_stall,
    output rpfd_pkg::frame_t frame
);
    import rpfd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rpfd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_stall (pulse_stall),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    rpfd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .pulse (pulse),
        .cmd   (cmd),
        .sts   (sts),
        .frame (frame)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rts_pulse_frame_decoder. A queue of line pulses
// (directed corners, then preamble-plus-frame sequences, broken sequences and
// noise on all four channels) feeds a clocked driver. A clocked monitor
// predicts the result of every accepted pulse and checks each output
// transaction in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

    import rpfd_pkg::*;

    localparam int          CH           = 4;
    localparam int unsigned DUR_MAX      = 131071;
    localparam int          NHALF        = FRAME_BYTES * 16;
    localparam int          RANDOM_ITEMS = 600;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          TAIL_CYCLES  = 40;

    // preamble tracker states
    localparam logic [1:0] PRE_IDLE  = 2'd0;
    localparam logic [1:0] PRE_WAKE  = 2'd1;
    localparam logic [1:0] PRE_GAP   = 2'd2;
    localparam logic [1:0] SOFT_IDLE = 2'd0;
    localparam logic [1:0] SOFT_SEEN = 2'd1;
    localparam logic [1:0] SOFT_DONE = 2'd2;

    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_SUM,
        SEQ_CUT,
        SEQ_BAD_PRE,
        SEQ_LONG_BIT,
        SEQ_STRAY
    } seq_kind_e;

    int unsigned corner_durs [33] = '{
        0, 1, 399, 400, 659, 660, 799, 800, 1100, 1101, 1199, 1200, 2000, 2001,
        2200, 2201, 2304, 2305, 2815, 2816, 4320, 4321, 5279, 5280, 11160, 11161,
        13639, 13640, 72540, 72541, 88659, 88660, 131071
    };

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   pulse_valid = 1'b0;
    logic   pulse_stall;
    pulse_t pulse       = '0;
    logic   frame_valid;
    logic   frame_stall = 1'b0;
    frame_t frame;

    rts_pulse_frame_decoder #(.CHANNELS(CH)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_stall (pulse_stall),
        .pulse       (pulse),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    pulse_t pulse_q [$];
    frame_t frame_expect_q [$];
    frame_t want;
    int     total_items     = 0;
    int     pulses_taken    = 0;
    int     err_count       = 0;
    int     cycle_count     = 0;
    int     send_idle_pct   = 0;
    int     recv_idle_pct   = 0;
    bit     pulse_taken_now = 1'b0;

    // per-channel decoder state
    bit         st_synced    [CH];
    logic [1:0] st_pre_stage [CH];
    logic [3:0] st_hsync_cnt [CH];
    logic [1:0] st_soft      [CH];
    bit         st_half_seen [CH];
    logic [7:0] st_shift     [CH];
    logic [2:0] st_bit_left  [CH];
    logic [2:0] st_byte_idx  [CH];
    logic [7:0] st_frame_mem [CH][FRAME_BYTES];

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit in_window(int unsigned d, int unsigned nom);
        int unsigned tol;
        tol = nom * TOL_NUM / TOL_DEN;
        return (d > nom - tol) && (d < nom + tol);
    endfunction

    function automatic void clear_channel(int ch);
        st_synced[ch]    = 1'b0;
        st_byte_idx[ch]  = 3'd0;
        st_half_seen[ch] = 1'b0;
        st_shift[ch]     = 8'h00;
        st_bit_left[ch]  = 3'd7;
    endfunction

    function automatic frame_t predict_frame(pulse_t p);
        frame_t      r;
        int          ch;
        int          i;
        bit          lvl;
        bit          sync_hit;
        int unsigned d;
        logic [7:0]  plain [FRAME_BYTES];
        logic [3:0]  sum;
        r   = '0;
        ch  = p.channel;
        lvl = p.level;
        d   = p.duration_us;
        if (!st_synced[ch])
        begin
            sync_hit = 1'b0;
            if (lvl && in_window(d, T_WAKE))
            begin
                st_pre_stage[ch] = PRE_WAKE;
            end
            else if (!lvl && st_pre_stage[ch] == PRE_WAKE && in_window(d, T_GAP))
            begin
                st_pre_stage[ch] = PRE_GAP;
                st_hsync_cnt[ch] = HSYNC_START;
            end
            else if (st_pre_stage[ch] == PRE_GAP && st_hsync_cnt[ch] != HSYNC_DONE &&
                     in_window(d, T_HSYNC))
            begin
                st_hsync_cnt[ch] = st_hsync_cnt[ch] + 4'd1;
            end
            else if (st_hsync_cnt[ch] == HSYNC_DONE && st_soft[ch] == SOFT_IDLE &&
                     in_window(d, T_SSYNC))
            begin
                st_soft[ch] = SOFT_SEEN;
            end
            else if (st_soft[ch] == SOFT_SEEN && d >= SYNC_END_MIN)
            begin
                d           = (d >= SYNC_END_CUT) ? d - SYNC_END_CUT : 0;
                st_soft[ch] = SOFT_DONE;
                sync_hit    = 1'b1;
            end
            else
            begin
                st_hsync_cnt[ch] = 4'd0;
                st_soft[ch]      = SOFT_IDLE;
            end
            if (!sync_hit)
                return r;
            st_synced[ch] = 1'b1;
            if (d < RESIDUE_MIN)
                return r;
        end
        while (d > 0)
        begin
            // long pulses are allowed only while the last byte is collected
            if (st_byte_idx[ch] != LAST_BYTE && d > BIT_MAX)
            begin
                clear_channel(ch);
                r.frame_status = STATUS_TIMING;
                return r;
            end
            d = (d > HALF_MAX) ? d / 2 : 0;
            if (!st_half_seen[ch])
            begin
                st_half_seen[ch] = 1'b1;
            end
            else
            begin
                st_half_seen[ch] = 1'b0;
                if (st_bit_left[ch] != 3'd0)
                begin
                    st_shift[ch]    = st_shift[ch] | (8'(lvl) << st_bit_left[ch]);
                    st_bit_left[ch] = st_bit_left[ch] - 3'd1;
                end
                else
                begin
                    st_frame_mem[ch][st_byte_idx[ch]] = st_shift[ch] | 8'(lvl);
                    st_shift[ch]    = 8'h00;
                    st_bit_left[ch] = 3'd7;
                    st_byte_idx[ch] = st_byte_idx[ch] + 3'd1;
                    if (st_byte_idx[ch] == 3'(FRAME_BYTES))
                    begin
                        st_synced[ch]   = 1'b0;
                        st_byte_idx[ch] = 3'd0;
                        // undo the XOR chaining, then fold all nibbles
                        plain[0] = st_frame_mem[ch][0];
                        for (i = 1; i < FRAME_BYTES; i++)
                            plain[i] = st_frame_mem[ch][i] ^ st_frame_mem[ch][i-1];
                        sum = 4'h0;
                        for (i = 0; i < FRAME_BYTES; i++)
                            sum = sum ^ ((i == 1) ? plain[1][7:4]
                                                  : (plain[i][7:4] ^ plain[i][3:0]));
                        r.frame_status   = (sum == plain[1][3:0]) ? STATUS_FRAME
                                                                  : STATUS_CHECKSUM;
                        r.frame_key      = plain[0];
                        r.command        = plain[1][7:4];
                        r.rolling_code   = {plain[2], plain[3]};
                        r.remote_address = {plain[6], plain[5], plain[4]};
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic pulse_t mk_pulse(int ch, bit lvl, int unsigned d);
        pulse_t p;
        p.channel     = 2'(ch);
        p.level       = lvl;
        p.duration_us = (d > DUR_MAX) ? DUR_W'(DUR_MAX) : DUR_W'(d);
        return p;
    endfunction

    // a length strictly inside the +/-10% window of nom
    function automatic int unsigned window_len(int unsigned nom);
        return $urandom_range(nom + nom / 10 - 1, nom - nom / 10 + 1);
    endfunction

    function automatic pulse_t noise_pulse(int ch);
        int unsigned d;
        int          c;
        case ($urandom_range(2))
            0:       d = $urandom_range(DUR_MAX, 0);
            1:       d = $urandom_range(3000, 0);
            default: d = corner_durs[$urandom_range(32)];
        endcase
        c = (ch < 0) ? int'($urandom_range(CH - 1)) : ch;
        return mk_pulse(c, 1'($urandom_range(1)), d);
    endfunction

    task automatic queue_frame(int ch, seq_kind_e kind);
        logic [7:0]  plain [FRAME_BYTES];
        logic [7:0]  air;
        logic [3:0]  sum;
        bit          halves [NHALF];
        pulse_t      seq [$];
        pulse_t      p;
        int          i;
        int          k;
        int          n;
        int          run;
        int          idx;
        int unsigned d;
        int unsigned nom;
        bit          carry;
        for (i = 0; i < FRAME_BYTES; i++)
            plain[i] = 8'($urandom);
        sum = 4'h0;
        for (i = 0; i < FRAME_BYTES; i++)
            sum = sum ^ ((i == 1) ? plain[1][7:4] : (plain[i][7:4] ^ plain[i][3:0]));
        plain[1][3:0] = sum ^ ((kind == SEQ_BAD_SUM) ? 4'($urandom_range(15, 1)) : 4'h0);
        air = 8'h00;
        for (i = 0; i < FRAME_BYTES; i++)
        begin
            air = plain[i] ^ air;
            for (k = 7; k >= 0; k--)
            begin
                halves[16 * i + 2 * (7 - k)]     = !air[k];
                halves[16 * i + 2 * (7 - k) + 1] = air[k];
            end
        end

        seq.push_back(mk_pulse(ch, 1'b1, window_len(T_WAKE)));
        seq.push_back(mk_pulse(ch, 1'b0, window_len(T_GAP)));
        for (i = 0; i < 4; i++)
            seq.push_back(mk_pulse(ch, 1'(i), window_len(T_HSYNC)));
        seq.push_back(mk_pulse(ch, 1'b1, window_len(T_SSYNC)));
        // sync end: a short pulse whose residue is dropped, or one carrying the first run
        carry = 1'($urandom_range(1));
        if (!carry)
            seq.push_back(mk_pulse(ch, 1'b0, $urandom_range(1199, 660)));
        n = 0;
        while (n < NHALF)
        begin
            run = (n + 1 < NHALF && halves[n + 1] == halves[n]) ? 2 : 1;
            d   = (run == 2) ? $urandom_range(1950, 1200) : $urandom_range(1050, 450);
            if (n + run == NHALF && $urandom_range(2) == 0)
                d = $urandom_range(DUR_MAX, 2500);
            if (carry)
                d = d + SYNC_END_CUT;
            carry = 1'b0;
            seq.push_back(mk_pulse(ch, halves[n], d));
            n = n + run;
        end

        case (kind)
            SEQ_CUT:
            begin
                idx = $urandom_range(seq.size() - 1, 1);
                while (seq.size() > idx)
                    void'(seq.pop_back());
            end
            SEQ_BAD_PRE:
            begin
                idx = $urandom_range(6);
                case (idx)
                    0:       nom = T_WAKE;
                    1:       nom = T_GAP;
                    6:       nom = T_SSYNC;
                    default: nom = T_HSYNC;
                endcase
                p = seq[idx];
                p.duration_us = DUR_W'($urandom_range(1) ? nom + nom / 10 : nom - nom / 10);
                seq[idx] = p;
            end
            SEQ_LONG_BIT:
            begin
                idx = $urandom_range(seq.size() - 1, 8);
                p = seq[idx];
                p.duration_us = DUR_W'($urandom_range(6000, 2001));
                seq[idx] = p;
            end
            SEQ_STRAY:
            begin
                seq.insert($urandom_range(seq.size() - 1, 1), noise_pulse(ch));
            end
            default:
            begin
            end
        endcase

        // other channels get the odd pulse in between
        for (i = 0; i < seq.size(); i++)
        begin
            if ($urandom_range(11) == 0)
                pulse_q.push_back(noise_pulse(int'((ch + $urandom_range(CH - 1, 1)) % CH)));
            pulse_q.push_back(seq[i]);
        end
    endtask

    initial
    begin
        int c;
        int r;
        int i;
        int target;
        for (c = 0; c < CH; c++)
        begin
            clear_channel(c);
            st_pre_stage[c] = PRE_IDLE;
            st_hsync_cnt[c] = 4'd0;
            st_soft[c]      = SOFT_IDLE;
            for (i = 0; i < FRAME_BYTES; i++)
                st_frame_mem[c][i] = 8'h00;
        end

        // directed: extremes and window edges
        pulse_q.push_back(mk_pulse(0, 1'b0, 0));
        pulse_q.push_back(mk_pulse(1, 1'b0, DUR_MAX));
        pulse_q.push_back(mk_pulse(2, 1'b1, 11160));
        pulse_q.push_back(mk_pulse(2, 1'b1, 13640));
        // channel 2: preamble at the inner window edges, sync end carrying data,
        // then a too-long data pulse
        pulse_q.push_back(mk_pulse(2, 1'b1, 11161));
        pulse_q.push_back(mk_pulse(2, 1'b0, 88659));
        pulse_q.push_back(mk_pulse(2, 1'b1, 2305));
        pulse_q.push_back(mk_pulse(2, 1'b0, 2815));
        pulse_q.push_back(mk_pulse(2, 1'b1, 2560));
        pulse_q.push_back(mk_pulse(2, 1'b0, 2560));
        pulse_q.push_back(mk_pulse(2, 1'b1, 4321));
        pulse_q.push_back(mk_pulse(2, 1'b1, 2080));
        pulse_q.push_back(mk_pulse(2, 1'b0, 2001));
        // channel 3: sync end at its minimum (residue floored), zero-length data,
        // a pulse taken whole and one just long enough to be halved
        pulse_q.push_back(mk_pulse(3, 1'b1, 13639));
        pulse_q.push_back(mk_pulse(3, 1'b0, 72541));
        for (i = 0; i < 4; i++)
            pulse_q.push_back(mk_pulse(3, 1'(i), 2560));
        pulse_q.push_back(mk_pulse(3, 1'b1, 5279));
        pulse_q.push_back(mk_pulse(3, 1'b0, 660));
        pulse_q.push_back(mk_pulse(3, 1'b1, 0));
        pulse_q.push_back(mk_pulse(3, 1'b1, 1100));
        pulse_q.push_back(mk_pulse(3, 1'b0, 1101));

        target = pulse_q.size() + RANDOM_ITEMS;
        while (pulse_q.size() < target)
        begin
            r = $urandom_range(99);
            c = $urandom_range(CH - 1);
            if (r < 20)
            begin
                for (i = $urandom_range(8, 1); i > 0; i--)
                    pulse_q.push_back(noise_pulse(-1));
            end
            else if (r < 60)
                queue_frame(c, SEQ_GOOD);
            else if (r < 68)
                queue_frame(c, SEQ_BAD_SUM);
            else if (r < 76)
                queue_frame(c, SEQ_CUT);
            else if (r < 84)
                queue_frame(c, SEQ_BAD_PRE);
            else if (r < 92)
                queue_frame(c, SEQ_LONG_BIT);
            else
                queue_frame(c, SEQ_STRAY);
        end
        total_items = pulse_q.size();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        wait (pulses_taken == total_items);
        wait (frame_expect_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // driver: one pulse transaction at a time, changed on the falling edge
    always @(negedge clk)
    begin
        if (pulses_taken < total_items / 3)
        begin
            send_idle_pct = 36;
            recv_idle_pct = 71;
        end
        else if (pulses_taken < 2 * total_items / 3)
        begin
            send_idle_pct = 71;
            recv_idle_pct = 36;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (!rst_n)
        begin
            pulse_valid <= 1'b0;
            frame_stall <= 1'b0;
        end
        else
        begin
            if (!pulse_valid || pulse_taken_now)
            begin
                pulse_taken_now = 1'b0;
                if (pulse_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pulse       <= pulse_q.pop_front();
                    pulse_valid <= 1'b1;
                end
                else
                    pulse_valid <= 1'b0;
            end
            frame_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predict on pulse acceptance, check on frame acceptance
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (rst_n && pulse_valid && !pulse_stall)
        begin
            frame_expect_q.push_back(predict_frame(pulse));
            pulses_taken    = pulses_taken + 1;
            pulse_taken_now = 1'b1;
        end
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (frame_expect_q.size() == 0)
            begin
                $error("frame transaction with nothing expected: %p", frame);
                err_count = err_count + 1;
            end
            else
            begin
                want = frame_expect_q.pop_front();
                if (frame.frame_status !== want.frame_status)
                begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, frame.frame_status);
                    err_count = err_count + 1;
                end
                if (frame.frame_key !== want.frame_key)
                begin
                    $error("frame_key: expected 0x%02h, actual 0x%02h",
                           want.frame_key, frame.frame_key);
                    err_count = err_count + 1;
                end
                if (frame.command !== want.command)
                begin
                    $error("command: expected 0x%01h, actual 0x%01h",
                           want.command, frame.command);
                    err_count = err_count + 1;
                end
                if (frame.rolling_code !== want.rolling_code)
                begin
                    $error("rolling_code: expected 0x%04h, actual 0x%04h",
                           want.rolling_code, frame.rolling_code);
                    err_count = err_count + 1;
                end
                if (frame.remote_address !== want.remote_address)
                begin
                    $error("remote_address: expected 0x%06h, actual 0x%06h",
                           want.remote_address, frame.remote_address);
                    err_count = err_count + 1;
                end
            end
        end
    end

endmodule
